FILE: rtl/qrs_pkg.sv
package qrs_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Per-word control that walks down every chain next to the data.
    typedef struct packed {
        logic valid;
        logic zero;   // leading coefficient is zero
        logic aneg;   // leading coefficient is negative
        logic dneg;   // discriminant is negative
    } t_ctl;

endpackage

FILE: rtl/qrs_sqrt_cell.sv
// One digit of a restoring square root: retires two radicand bits per cell.
module qrs_sqrt_cell #(
    parameter int DW  = 66,
    parameter int SW  = 33,
    parameter int SBW = 67
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  qrs_pkg::t_ctl       i_ctl,
    input  logic [SW+1:0]       i_rem,
    input  logic [SW-1:0]       i_root,
    input  logic [DW-1:0]       i_rad,
    input  logic [SBW-1:0]      i_sb,
    output qrs_pkg::t_ctl       o_ctl,
    output logic [SW+1:0]       o_rem,
    output logic [SW-1:0]       o_root,
    output logic [DW-1:0]       o_rad,
    output logic [SBW-1:0]      o_sb
);

    localparam int RW = SW + 2;

    logic [RW+1:0]  w_try_rem;
    logic [RW+1:0]  w_trial;
    logic [RW+1:0]  w_diff;
    logic           w_ge;
    logic [RW-1:0]  n_rem;
    logic [SW-1:0]  n_root;
    logic [DW-1:0]  n_rad;

    qrs_pkg::t_ctl  r_ctl;
    logic [RW-1:0]  r_rem;
    logic [SW-1:0]  r_root;
    logic [DW-1:0]  r_rad;
    logic [SBW-1:0] r_sb;

    assign w_try_rem = {i_rem, i_rad[DW-1:DW-2]};
    assign w_trial   = {2'b00, i_root, 2'b01};
    assign w_ge      = (w_try_rem >= w_trial);
    assign w_diff    = w_try_rem - w_trial;

    assign n_rem  = w_ge ? w_diff[RW-1:0] : w_try_rem[RW-1:0];
    assign n_root = {i_root[SW-2:0], w_ge};
    assign n_rad  = {i_rad[DW-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_sb   <= i_sb;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_sb   = r_sb;

endmodule

FILE: rtl/qrs_div_cell.sv
// One quotient bit of a restoring divide; the divisor rides along.
module qrs_div_cell #(
    parameter int W   = 32,
    parameter int SBW = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  qrs_pkg::t_ctl   i_ctl,
    input  logic [W:0]      i_rem,
    input  logic [W-1:0]    i_xl,
    input  logic [W-1:0]    i_q,
    input  logic [W:0]      i_d,
    input  logic [SBW-1:0]  i_sb,
    output qrs_pkg::t_ctl   o_ctl,
    output logic [W:0]      o_rem,
    output logic [W-1:0]    o_xl,
    output logic [W-1:0]    o_q,
    output logic [W:0]      o_d,
    output logic [SBW-1:0]  o_sb
);

    logic [W+1:0]   w_try;
    logic [W+1:0]   w_diff;
    logic           w_ge;
    logic [W:0]     n_rem;
    logic [W-1:0]   n_xl;
    logic [W-1:0]   n_q;

    qrs_pkg::t_ctl  r_ctl;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_xl;
    logic [W-1:0]   r_q;
    logic [W:0]     r_d;
    logic [SBW-1:0] r_sb;

    assign w_try  = {i_rem, i_xl[W-1]};
    assign w_ge   = (w_try >= {1'b0, i_d});
    assign w_diff = w_try - {1'b0, i_d};

    assign n_rem = w_ge ? w_diff[W:0] : w_try[W:0];
    assign n_q   = {i_q[W-2:0], w_ge};
    assign n_xl  = {i_xl[W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_xl  <= n_xl;
            r_q   <= n_q;
            r_d   <= i_d;
            r_sb  <= i_sb;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_xl  = r_xl;
    assign o_q   = r_q;
    assign o_d   = r_d;
    assign o_sb  = r_sb;

endmodule

FILE: rtl/quadratic_root_solver_top.sv
// Quadratic root solver: roots of a*x^2 + b*x + c = 0, signed fixed point
// (COEF_WIDTH bits, FRAC_BITS fraction, Q16.16 by default).
// Input channel (s_): one word carries a, b, c. Output channel (m_): one word
// per input word with the four root parts, and tuser flags is_complex,
// zero_leading and saturated.
// Each root part is the exact quotient rounded half away from zero and
// clamped to the signed range; a clamp sets saturated. A zero leading
// coefficient gives all-zero roots with zero_leading set.
// Pipeline from input accept to o_m_tvalid: 3 front stages (magnitudes,
// products, discriminant), one square-root cell per root bit (COEF_WIDTH+1),
// 2 divide setup stages, one divide cell per quotient bit (COEF_WIDTH), and
// the output register. Throughput: one word per cycle while the pipe is not
// stalled; every stage is a separate register.
// Stall: the whole pipe advances on one enable, high while the output
// register is empty or being taken. When the receiver holds i_m_tready low
// with a word waiting, the pipe freezes and o_s_tready drops.
// Reset clears all valid bits; the pipe is empty and ready afterwards.
module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // coef_a, coef_b, coef_c
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]   i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // root1_re, root1_im, root2_re, root2_im
    output logic [((4*COEF_WIDTH+7)/8)*8-1:0]   o_m_tdata,
    // is_complex, zero_leading, saturated
    output logic [2:0]                          o_m_tuser
);

    localparam int W     = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((4*W+7)/8)*8;
    localparam int DW    = 2*W + 2;        // discriminant
    localparam int SW    = W + 1;          // square root
    localparam int NW    = W + 3;          // signed numerator
    localparam int MW    = W + 2;          // numerator magnitude
    localparam int XW    = MW + F + 1;     // scaled numerator plus half divisor
    localparam int TW    = (F + 3 > W + 1) ? F + 3 : W + 1;
    localparam int SQSB  = NW + W;

    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- stage 0: magnitudes ----------------
    logic [W-1:0]  w_a, w_b, w_c;
    assign w_a = i_s_tdata[W-1:0];
    assign w_b = i_s_tdata[2*W-1:W];
    assign w_c = i_s_tdata[3*W-1:2*W];

    qrs_pkg::t_ctl r0_ctl;
    logic [W-1:0]  r0_amag, r0_bmag, r0_cmag;
    logic          r0_bneg, r0_cneg;
    qrs_pkg::t_ctl n0_ctl;

    always_comb begin
        n0_ctl       = '0;
        n0_ctl.valid = i_s_tvalid;
        n0_ctl.zero  = (w_a == '0);
        n0_ctl.aneg  = w_a[W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else if (w_en) begin
            r0_ctl <= n0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_amag <= w_a[W-1] ? -w_a : w_a;
            r0_bmag <= w_b[W-1] ? -w_b : w_b;
            r0_cmag <= w_c[W-1] ? -w_c : w_c;
            r0_bneg <= w_b[W-1];
            r0_cneg <= w_c[W-1];
        end
    end

    // ---------------- stage 1: products ----------------
    qrs_pkg::t_ctl        r1_ctl;
    logic [2*W-1:0]       r1_bsq, r1_ac;
    logic [W-1:0]         r1_amag;
    logic                 r1_same;
    logic signed [NW-1:0] r1_nb;
    logic [NW-1:0]        w_bext;

    assign w_bext = {3'b000, r0_bmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (w_en) begin
            r1_ctl <= r0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bsq  <= r0_bmag * r0_bmag;
            r1_ac   <= r0_amag * r0_cmag;
            r1_amag <= r0_amag;
            r1_same <= (r0_ctl.aneg == r0_cneg);
            r1_nb   <= r0_bneg ? signed'(w_bext) : -signed'(w_bext);
        end
    end

    // ---------------- stage 2: discriminant ----------------
    logic [DW-1:0] w_bsq, w_ac4, w_disc;
    logic          w_dneg;
    qrs_pkg::t_ctl n2_ctl;

    assign w_bsq  = {2'b00, r1_bsq};
    assign w_ac4  = {r1_ac, 2'b00};
    assign w_dneg = r1_same && (w_ac4 > w_bsq);

    always_comb begin
        if (!r1_same) begin
            w_disc = w_bsq + w_ac4;
        end else if (w_dneg) begin
            w_disc = w_ac4 - w_bsq;
        end else begin
            w_disc = w_bsq - w_ac4;
        end
        n2_ctl      = r1_ctl;
        n2_ctl.dneg = w_dneg;
    end

    qrs_pkg::t_ctl        r2_ctl;
    logic [DW-1:0]        r2_disc;
    logic [SQSB-1:0]      r2_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (w_en) begin
            r2_ctl <= n2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_disc <= w_disc;
            r2_sb   <= {r1_nb, r1_amag};
        end
    end

    // ---------------- square root chain ----------------
    qrs_pkg::t_ctl   w_sq_ctl  [0:SW];
    logic [SW+1:0]   w_sq_rem  [0:SW];
    logic [SW-1:0]   w_sq_root [0:SW];
    logic [DW-1:0]   w_sq_rad  [0:SW];
    logic [SQSB-1:0] w_sq_sb   [0:SW];

    assign w_sq_ctl[0]  = r2_ctl;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = r2_disc;
    assign w_sq_sb[0]   = r2_sb;

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .DW  (DW),
            .SW  (SW),
            .SBW (SQSB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_sq_ctl[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_rad   (w_sq_rad[k]),
            .i_sb    (w_sq_sb[k]),
            .o_ctl   (w_sq_ctl[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_rad   (w_sq_rad[k+1]),
            .o_sb    (w_sq_sb[k+1])
        );
    end

    // ---------------- stage 3: numerators ----------------
    qrs_pkg::t_ctl        w_s3_ctl;
    logic signed [NW-1:0] w_nb, w_sext, w_num_a, w_num_b;
    logic [NW-1:0]        w_abs_a, w_abs_b;
    logic [W-1:0]         w_s3_amag;

    assign w_s3_ctl  = w_sq_ctl[SW];
    assign w_nb      = signed'(w_sq_sb[SW][SQSB-1:W]);
    assign w_s3_amag = w_sq_sb[SW][W-1:0];
    assign w_sext    = signed'({{(NW-SW){1'b0}}, w_sq_root[SW]});
    // complex: lane A is -b, lane B is +sqrt; real: -b+sqrt and -b-sqrt
    assign w_num_a   = w_s3_ctl.dneg ? w_nb   : w_nb + w_sext;
    assign w_num_b   = w_s3_ctl.dneg ? w_sext : w_nb - w_sext;
    assign w_abs_a   = w_num_a[NW-1] ? -w_num_a : w_num_a;
    assign w_abs_b   = w_num_b[NW-1] ? -w_num_b : w_num_b;

    qrs_pkg::t_ctl r3_ctl;
    logic [MW-1:0] r3_ma, r3_mb;
    logic          r3_sa, r3_sb;
    logic [W-1:0]  r3_amag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (w_en) begin
            r3_ctl <= w_s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ma   <= w_abs_a[MW-1:0];
            r3_mb   <= w_abs_b[MW-1:0];
            r3_sa   <= w_num_a[NW-1];
            r3_sb   <= w_num_b[NW-1];
            r3_amag <= r3_amag_nx(w_s3_amag);
        end
    end

    function automatic logic [W-1:0] r3_amag_nx(input logic [W-1:0] v);
        return v;
    endfunction

    // ---------------- stage 4: divide setup ----------------
    // x = m*2^F + |a|; quotient x / 2|a| gives round half away from zero.
    // The top of x is checked against the divisor so only W quotient bits
    // remain for the cells.
    logic [XW-1:0] w_xa, w_xb, w_aext;
    logic [W:0]    w_d;
    logic [TW-1:0] w_top_a, w_top_b, w_dt;

    assign w_aext  = {{(XW-W){1'b0}}, r3_amag};
    assign w_xa    = {1'b0, r3_ma, {F{1'b0}}} + w_aext;
    assign w_xb    = {1'b0, r3_mb, {F{1'b0}}} + w_aext;
    assign w_d     = {r3_amag, 1'b0};
    assign w_top_a = TW'(w_xa[XW-1:W]);
    assign w_top_b = TW'(w_xb[XW-1:W]);
    assign w_dt    = TW'(w_d);

    qrs_pkg::t_ctl r4_ctl;
    logic [W:0]    r4_rem_a, r4_rem_b, r4_d;
    logic [W-1:0]  r4_xl_a, r4_xl_b;
    logic [1:0]    r4_sb_a, r4_sb_b;   // {overflow, numerator sign}

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (w_en) begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_rem_a <= w_top_a[W:0];
            r4_rem_b <= w_top_b[W:0];
            r4_xl_a  <= w_xa[W-1:0];
            r4_xl_b  <= w_xb[W-1:0];
            r4_d     <= w_d;
            r4_sb_a  <= {w_top_a >= w_dt, r3_sa};
            r4_sb_b  <= {w_top_b >= w_dt, r3_sb};
        end
    end

    // ---------------- divide chains, two lanes ----------------
    qrs_pkg::t_ctl w_da_ctl [0:W];
    qrs_pkg::t_ctl w_db_ctl [0:W];
    logic [W:0]    w_da_rem [0:W];
    logic [W:0]    w_db_rem [0:W];
    logic [W-1:0]  w_da_xl  [0:W];
    logic [W-1:0]  w_db_xl  [0:W];
    logic [W-1:0]  w_da_q   [0:W];
    logic [W-1:0]  w_db_q   [0:W];
    logic [W:0]    w_da_d   [0:W];
    logic [W:0]    w_db_d   [0:W];
    logic [1:0]    w_da_sb  [0:W];
    logic [1:0]    w_db_sb  [0:W];

    assign w_da_ctl[0] = r4_ctl;
    assign w_db_ctl[0] = r4_ctl;
    assign w_da_rem[0] = r4_rem_a;
    assign w_db_rem[0] = r4_rem_b;
    assign w_da_xl[0]  = r4_xl_a;
    assign w_db_xl[0]  = r4_xl_b;
    assign w_da_q[0]   = '0;
    assign w_db_q[0]   = '0;
    assign w_da_d[0]   = r4_d;
    assign w_db_d[0]   = r4_d;
    assign w_da_sb[0]  = r4_sb_a;
    assign w_db_sb[0]  = r4_sb_b;

    for (genvar k = 0; k < W; k++) begin : g_div
        qrs_div_cell #(.W(W), .SBW(2)) u_lane_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_da_ctl[k]),
            .i_rem   (w_da_rem[k]),
            .i_xl    (w_da_xl[k]),
            .i_q     (w_da_q[k]),
            .i_d     (w_da_d[k]),
            .i_sb    (w_da_sb[k]),
            .o_ctl   (w_da_ctl[k+1]),
            .o_rem   (w_da_rem[k+1]),
            .o_xl    (w_da_xl[k+1]),
            .o_q     (w_da_q[k+1]),
            .o_d     (w_da_d[k+1]),
            .o_sb    (w_da_sb[k+1])
        );
        qrs_div_cell #(.W(W), .SBW(2)) u_lane_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_db_ctl[k]),
            .i_rem   (w_db_rem[k]),
            .i_xl    (w_db_xl[k]),
            .i_q     (w_db_q[k]),
            .i_d     (w_db_d[k]),
            .i_sb    (w_db_sb[k]),
            .o_ctl   (w_db_ctl[k+1]),
            .o_rem   (w_db_rem[k+1]),
            .o_xl    (w_db_xl[k+1]),
            .o_q     (w_db_q[k+1]),
            .o_d     (w_db_d[k+1]),
            .o_sb    (w_db_sb[k+1])
        );
    end

    // ---------------- output: sign, clamp, select ----------------
    // returns {saturated, value}
    function automatic logic [W:0] clamp(input logic [W-1:0] q, input logic ovf,
                                         input logic neg);
        logic [W-1:0] lim;
        logic         sat;
        logic [W-1:0] mag;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sat = ovf || (q > lim);
        mag = sat ? lim : q;
        return {sat, neg ? -mag : mag};
    endfunction

    qrs_pkg::t_ctl w_f_ctl;
    logic [W:0]    w_ca, w_cb, w_cb2;
    logic [W-1:0]  n_r1re, n_r1im, n_r2re, n_r2im;
    logic [2:0]    n_user;

    assign w_f_ctl = w_da_ctl[W];
    assign w_ca  = clamp(w_da_q[W], w_da_sb[W][1], w_da_sb[W][0] ^ w_f_ctl.aneg);
    assign w_cb  = clamp(w_db_q[W], w_db_sb[W][1], w_db_sb[W][0] ^ w_f_ctl.aneg);
    assign w_cb2 = clamp(w_db_q[W], w_db_sb[W][1], !w_db_sb[W][0] ^ w_f_ctl.aneg);

    always_comb begin
        n_r1re = '0;
        n_r1im = '0;
        n_r2re = '0;
        n_r2im = '0;
        n_user = 3'b010;
        if (!w_f_ctl.zero) begin
            n_r1re = w_ca[W-1:0];
            if (w_f_ctl.dneg) begin
                n_r1im = w_cb[W-1:0];
                n_r2re = w_ca[W-1:0];
                n_r2im = w_cb2[W-1:0];
                n_user = {w_ca[W] | w_cb[W] | w_cb2[W], 1'b0, 1'b1};
            end else begin
                n_r2re = w_cb[W-1:0];
                n_user = {w_ca[W] | w_cb[W], 1'b0, 1'b0};
            end
        end
    end

    logic [W-1:0] r_r1re, r_r1im, r_r2re, r_r2im;
    logic [2:0]   r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_f_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1re <= n_r1re;
            r_r1im <= n_r1im;
            r_r2re <= n_r2re;
            r_r2im <= n_r2im;
            r_user <= n_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_r2im, r_r2re, r_r1im, r_r1re});
    assign o_m_tuser  = r_user;

endmodule

FILE: verif/quadratic_root_solver_top_test.sv
module quadratic_root_solver_top_test;

    localparam int W       = qrs_pkg::COEF_WIDTH;
    localparam int LATENCY = 2 * W + 7;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        logic [W-1:0] r1_re;
        logic [W-1:0] r1_im;
        logic [W-1:0] r2_re;
        logic [W-1:0] r2_im;
        logic         cplx;
        logic         zlead;
        logic         sat;
    } t_roots;

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [((3*W+7)/8)*8-1:0] i_s_tdata;  // coef_a, coef_b, coef_c
    logic o_m_tvalid;
    logic i_m_tready;
    logic [((4*W+7)/8)*8-1:0] o_m_tdata;  // root1_re, root1_im, root2_re, root2_im
    logic [2:0] o_m_tuser;                // is_complex, zero_leading, saturated

    quadratic_root_solver_top dut (.*);

    t_roots roots_due[$];
    int     err_cnt;
    int     cycle_cnt;
    int     send_idle_pct;
    int     recv_stall_pct;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Rounded quotient round(num * 2^F / 2a), ties away from zero, clamped to W bits.
    function automatic logic [W-1:0] div_part(input logic signed [2*W+1:0] num,
                                              input logic [W:0] amag, input logic aneg,
                                              inout logic sat);
        logic          nneg;
        logic [2*W+1:0] mag;
        logic [3*W:0]  x;
        logic [3*W:0]  q;
        logic [W:0]    lim;
        logic          neg;
        nneg = num < 0;
        mag  = nneg ? -num : num;
        x    = ({{(W-1){1'b0}}, mag} << qrs_pkg::FRAC_BITS) + amag;
        q    = x / ({amag, 1'b0});
        neg  = nneg ^ aneg;
        lim  = neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        div_part = neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    function automatic t_roots solve_roots(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] c);
        t_roots r;
        logic [W:0]     amag;
        logic [W:0]     bmag;
        logic [W:0]     cmag;
        logic [2*W+3:0] bsq;
        logic [2*W+3:0] ac4;
        logic [2*W+3:0] disc;
        logic [W+1:0]   s;
        logic [W+1:0]   t;
        logic signed [2*W+1:0] nb;
        logic sat;
        r    = '0;
        sat  = 1'b0;
        amag = a[W-1] ? -{a[W-1], a} : {1'b0, a};
        bmag = b[W-1] ? -{b[W-1], b} : {1'b0, b};
        cmag = c[W-1] ? -{c[W-1], c} : {1'b0, c};
        if (amag == 0) begin
            r.zlead = 1'b1;
            return r;
        end
        bsq = bmag * bmag;
        ac4 = (amag * cmag) << 2;
        if (a[W-1] != c[W-1]) begin
            disc = bsq + ac4;
        end else if (bsq >= ac4) begin
            disc = bsq - ac4;
        end else begin
            disc   = ac4 - bsq;
            r.cplx = 1'b1;
        end
        s = '0;
        for (int i = W + 1; i >= 0; i--) begin
            t = s | ((W + 2)'(1) << i);
            if ({{(2*W+4){1'b0}}, disc} >= t * t) s = t;
        end
        nb = b[W-1] ? $signed({1'b0, bmag}) : -$signed({1'b0, bmag});
        if (!r.cplx) begin
            r.r1_re = div_part(nb + s, amag, a[W-1], sat);
            r.r2_re = div_part(nb - s, amag, a[W-1], sat);
        end else begin
            r.r1_re = div_part(nb, amag, a[W-1], sat);
            r.r1_im = div_part(s, amag, a[W-1], sat);
            r.r2_re = r.r1_re;
            r.r2_im = div_part(-$signed({1'b0, s}), amag, a[W-1], sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic send_coefs(input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c, b, a};
        roots_due.push_back(solve_roots(a, b, c));
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (roots_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Receiver stall pattern and cycle guard.
    always @(posedge i_clk) begin
        cycle_cnt  <= cycle_cnt + 1;
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycle_cnt > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Compare each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        t_roots exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (roots_due.size() == 0) begin
                $error("unexpected output word");
                err_cnt++;
            end else begin
                exp_r = roots_due.pop_front();
                if (o_m_tdata[W-1:0] !== exp_r.r1_re) begin
                    $error("root1_re exp %h got %h", exp_r.r1_re, o_m_tdata[W-1:0]);
                    err_cnt++;
                end
                if (o_m_tdata[2*W-1:W] !== exp_r.r1_im) begin
                    $error("root1_im exp %h got %h", exp_r.r1_im, o_m_tdata[2*W-1:W]);
                    err_cnt++;
                end
                if (o_m_tdata[3*W-1:2*W] !== exp_r.r2_re) begin
                    $error("root2_re exp %h got %h", exp_r.r2_re, o_m_tdata[3*W-1:2*W]);
                    err_cnt++;
                end
                if (o_m_tdata[4*W-1:3*W] !== exp_r.r2_im) begin
                    $error("root2_im exp %h got %h", exp_r.r2_im, o_m_tdata[4*W-1:3*W]);
                    err_cnt++;
                end
                if (o_m_tuser[0] !== exp_r.cplx) begin
                    $error("is_complex exp %b got %b", exp_r.cplx, o_m_tuser[0]);
                    err_cnt++;
                end
                if (o_m_tuser[1] !== exp_r.zlead) begin
                    $error("zero_leading exp %b got %b", exp_r.zlead, o_m_tuser[1]);
                    err_cnt++;
                end
                if (o_m_tuser[2] !== exp_r.sat) begin
                    $error("saturated exp %b got %b", exp_r.sat, o_m_tuser[2]);
                    err_cnt++;
                end
            end
        end
    end

    localparam logic [W-1:0] ONE  = 1 << qrs_pkg::FRAC_BITS;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    task automatic test_directed();
        send_coefs(0, ONE, ONE);                 // zero leading coefficient
        send_coefs(0, MINV, MAXV);
        send_coefs(ONE, -(3 * ONE), 2 * ONE);    // real roots 2 and 1
        send_coefs(ONE, -(2 * ONE), ONE);        // zero discriminant
        send_coefs(ONE, 0, ONE);                 // +/- i
        send_coefs(-ONE, 0, -ONE);               // complex, negative a
        send_coefs(-ONE, ONE, 2 * ONE);
        send_coefs(1, MAXV, MAXV);               // clamps
        send_coefs(1, MINV, MINV);
        send_coefs(1, 0, 1);
        send_coefs(-1, 0, -1);
        send_coefs(MAXV, MAXV, MAXV);
        send_coefs(MINV, MINV, MINV);
        send_coefs(MINV, MAXV, MINV);
        send_coefs(MAXV, MINV, MAXV);
        send_coefs(MINV, 0, MAXV);
        send_coefs('1, '1, '1);
        send_coefs(1, 1, 0);
        send_coefs(ONE, 0, 0);
        send_coefs(MAXV, 0, MINV);
    endtask

    function automatic logic [W-1:0] rand_coef();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $signed($urandom_range(2 * ONE * 8) - ONE * 8);
            2:       return $signed($urandom_range(64) - 32);
            3:       return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
            default: return ($urandom_range(1) ? 1 : -1) * ($urandom_range(20) * ONE);
        endcase
    endfunction

    task automatic test_random(input int n);
        logic [W-1:0] a;
        for (int i = 0; i < n; i++) begin
            a = ($urandom_range(30) == 0) ? '0 : rand_coef();
            send_coefs(a, rand_coef(), rand_coef());
        end
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    initial begin
        err_cnt    = 0;
        cycle_cnt  = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        set_idling(0, 0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400);
        set_idling(83, 0);
        test_random(250);
        set_idling(0, 83);
        test_random(250);
        set_idling(25, 25);
        test_random(300);
        set_idling(0, 0);
        test_random(100);
        drain();

        if (err_cnt == 0 && roots_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_top.sv
verif/quadratic_root_solver_top_test.sv
